// File: hw/rtl/spfr_pkg.sv
// ---------------------------------------------------------------------------
// spfr_pkg
// Shared types, register indexes and constants for the serial packet frame
// receiver.
// ---------------------------------------------------------------------------
package spfr_pkg;

  // Configuration register indexes
  localparam int CfgAddrWidth = 2;
  typedef enum logic [CfgAddrWidth-1:0] {
    REG_SYNC_BYTE  = 2'd0,
    REG_MIN_LENGTH = 2'd1,
    REG_MAX_LENGTH = 2'd2
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0] SYNC_RESET = 8'hF0;
  localparam logic [7:0] MIN_RESET  = 8'd5;
  localparam logic [7:0] MAX_RESET  = 8'd250;

  // Frame constants
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;
  localparam logic [7:0] TAG_HEADER   = 8'd4;
  localparam logic [7:0] TAG_CAP      = 8'd100;
  localparam logic [7:0] TAG_BAD      = 8'd2;
  localparam logic [7:0] TAG_EMPTY    = 8'd1;
  // x / 3 == (x * 171) >> 9 for every 8-bit x
  localparam logic [7:0] DIV3_MUL     = 8'd171;
  localparam int         DIV3_SHIFT   = 9;

  // Input item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  // Framing phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_SERIAL  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] min_length;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       overrun;
  } item_t;

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_data;
    logic       packet_ready;
    logic       frame_good;
    logic       frame_end;
    logic       direction;
    logic [7:0] tag_count;
    logic [7:0] serial_number;
    logic       empty_packet;
  } result_t;

endpackage

// File: hw/rtl/spfr_in_stage.sv
// ---------------------------------------------------------------------------
// spfr_in_stage
// Input register: holds one accepted word until the framer takes it.
// ---------------------------------------------------------------------------
module spfr_in_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [spfr_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] data
  input  logic [spfr_pkg::IN_TUSER_W-1:0]     s_tuser,  // [0] op, [1] overrun
  input  logic                                take,
  output logic                                item_valid,
  output spfr_pkg::item_t                     item
);
  import spfr_pkg::*;

  // free when empty or being drained this cycle
  assign s_tready = !item_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.op      <= s_tuser[0];
      item.data    <= s_tdata;
      item.overrun <= s_tuser[1];
    end
  end

endmodule

// File: hw/rtl/spfr_framer.sv
// ---------------------------------------------------------------------------
// spfr_framer
// Configuration registers, framing state and the per-word next-state logic.
// ---------------------------------------------------------------------------
module spfr_framer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [spfr_pkg::CfgAddrWidth-1:0]   cfg_addr,
  input  logic [7:0]                          cfg_wdata,
  input  logic                                step,
  input  spfr_pkg::item_t                     item,
  output spfr_pkg::result_t                   result
);
  import spfr_pkg::*;

  cfg_t       cfg;
  phase_t     phase, phase_next;
  logic [7:0] checksum, checksum_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] write_index, write_index_next;
  logic [7:0] tags, tags_next;
  logic [7:0] serial_reg, serial_reg_next;
  logic       empty_flag, empty_flag_next;
  logic       ready_flag, ready_flag_next;
  logic       dir_flag, dir_flag_next;

  logic [7:0]  tags_sub;
  logic [15:0] div_prod;
  logic [7:0]  tags_val;
  logic [7:0]  rem_dec;
  logic        good, fend;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte  <= SYNC_RESET;
      cfg.min_length <= MIN_RESET;
      cfg.max_length <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SYNC_BYTE:  cfg.sync_byte  <= cfg_wdata;
        REG_MIN_LENGTH: cfg.min_length <= cfg_wdata;
        REG_MAX_LENGTH: cfg.max_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // length field minus header, divided by three
  assign tags_sub = tags - TAG_HEADER;
  assign div_prod = tags_sub * DIV3_MUL;
  assign rem_dec  = remaining - 8'd1;

  // next state for one word
  always_comb begin
    phase_next       = phase;
    checksum_next    = checksum;
    remaining_next   = remaining;
    write_index_next = write_index;
    tags_next        = tags;
    serial_reg_next  = serial_reg;
    empty_flag_next  = empty_flag;
    ready_flag_next  = ready_flag;
    dir_flag_next    = dir_flag;
    tags_val         = tags_sub;
    good             = 1'b0;
    fend             = 1'b0;
    result           = '0;

    if (item.op == OP_ACK) begin
      ready_flag_next = 1'b0;
    end else if (!item.overrun && !ready_flag) begin
      result.store_valid = 1'b1;
      result.store_index = write_index;
      result.store_data  = item.data;
      case (phase)
        PH_HUNT: begin
          checksum_next = checksum + item.data;
          if (item.data == cfg.sync_byte) begin
            write_index_next = 8'd1;
            phase_next       = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          write_index_next = write_index + 8'd1;
          checksum_next    = checksum + item.data;
          tags_next        = item.data;
          if (item.data > cfg.max_length || item.data < cfg.min_length) begin
            write_index_next = '0;
            phase_next       = PH_HUNT;
            checksum_next    = '0;
          end else begin
            remaining_next = item.data - LEN_OVERHEAD;
            phase_next     = PH_SERIAL;
          end
        end
        PH_SERIAL: begin
          write_index_next = write_index + 8'd1;
          checksum_next    = checksum + item.data;
          serial_reg_next  = item.data;
          remaining_next   = rem_dec;
          phase_next       = PH_PAYLOAD;
          empty_flag_next  = (tags_sub == TAG_EMPTY);
          if (tags_sub == TAG_EMPTY) begin
            tags_val = tags_sub;
          end else if (tags_sub == TAG_BAD) begin
            // bad frame: start over
            tags_val         = tags_sub;
            write_index_next = '0;
            phase_next       = PH_HUNT;
            checksum_next    = '0;
          end else begin
            tags_val = {1'b0, div_prod[15:DIV3_SHIFT]};
          end
          tags_next = (tags_val > TAG_CAP) ? TAG_CAP : tags_val;
        end
        default: begin
          remaining_next   = rem_dec;
          write_index_next = write_index + 8'd1;
          if (rem_dec == 8'd0) begin
            // checksum byte closes the frame
            fend = 1'b1;
            if (checksum == item.data) begin
              good            = 1'b1;
              dir_flag_next   = !dir_flag;
              ready_flag_next = 1'b1;
            end
            write_index_next = '0;
            phase_next       = PH_HUNT;
            checksum_next    = '0;
          end else begin
            checksum_next = checksum + item.data;
          end
        end
      endcase
    end

    result.packet_ready  = ready_flag_next;
    result.frame_good    = good;
    result.frame_end     = fend;
    result.direction     = dir_flag_next;
    result.tag_count     = tags_next;
    result.serial_number = serial_reg_next;
    result.empty_packet  = empty_flag_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      checksum    <= '0;
      remaining   <= '0;
      write_index <= '0;
      tags        <= '0;
      serial_reg  <= '0;
      empty_flag  <= 1'b0;
      ready_flag  <= 1'b0;
      dir_flag    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      checksum    <= checksum_next;
      remaining   <= remaining_next;
      write_index <= write_index_next;
      tags        <= tags_next;
      serial_reg  <= serial_reg_next;
      empty_flag  <= empty_flag_next;
      ready_flag  <= ready_flag_next;
      dir_flag    <= dir_flag_next;
    end
  end

endmodule

// File: hw/rtl/spfr_out_stage.sv
// ---------------------------------------------------------------------------
// spfr_out_stage
// Result register driving the master stream side.
// ---------------------------------------------------------------------------
module spfr_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  spfr_pkg::result_t                   result,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] store_valid, [8:1] store_index, [16:9] store_data, [17] packet_ready,
  // [18] frame_good, [19] frame_end, [20] direction, [28:21] tag_count,
  // [36:29] serial_number, [37] empty_packet, [39:38] zero
  output logic [spfr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                can_load
);
  import spfr_pkg::*;

  result_t held;

  assign can_load = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

  // pack, first field lowest
  assign m_tdata = {2'b00, held.empty_packet, held.serial_number, held.tag_count,
                    held.direction, held.frame_end, held.frame_good,
                    held.packet_ready, held.store_data, held.store_index,
                    held.store_valid};

endmodule

// File: hw/rtl/serial_packet_frame_receiver.sv
// ---------------------------------------------------------------------------
// serial_packet_frame_receiver
// Frames packets out of a received serial byte stream.
//
// Slave stream: one word per received byte or acknowledge. tdata carries the
// byte, tuser[0] is the opcode (1 = acknowledge, clears the ready flag) and
// tuser[1] marks an overrun byte, which is dropped.
// Master stream: exactly one result word for each input word, in order.
// Config port: cfg_we / cfg_addr / cfg_wdata write sync byte (0), minimum
// length (1) and maximum length (2); write only while the block is idle.
// Path: an accepted word passes the input register, then framer logic into
// the result register.
// Throughput: one word per cycle unless m_tready stalls; the framing state
// loop is compare/add logic plus an 8x8 multiply for the divide by three.
// Reset (rst, synchronous): stream valids drop, framing state clears and the
// registers return to 0xF0 / 5 / 250.
// A stall on m_tready holds the result register; the input register still
// takes one more word if empty, then s_tready drops until the result is taken.
// ---------------------------------------------------------------------------
module serial_packet_frame_receiver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [spfr_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] data
  input  logic [spfr_pkg::IN_TUSER_W-1:0]     s_tuser,  // [0] op, [1] overrun
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] store_valid, [8:1] store_index, [16:9] store_data, [17] packet_ready,
  // [18] frame_good, [19] frame_end, [20] direction, [28:21] tag_count,
  // [36:29] serial_number, [37] empty_packet, [39:38] zero
  output logic [spfr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [spfr_pkg::CfgAddrWidth-1:0]   cfg_addr,
  input  logic [7:0]                          cfg_wdata
);
  import spfr_pkg::*;

  item_t   item;
  result_t result;
  logic    item_valid;
  logic    can_load;
  logic    step;

  // a held word moves on whenever the result register can take it
  assign step = item_valid && can_load;

  spfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  spfr_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  spfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .can_load (can_load)
  );

endmodule

// File: hw/rtl/spfr_checker.sv
// ---------------------------------------------------------------------------
// spfr_checker
// Port-level checks for the serial packet frame receiver.
// ---------------------------------------------------------------------------
module spfr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [spfr_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import spfr_pkg::*;

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // good frame is also a frame end with a store and raises ready
  a_good_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[19] && m_tdata[17] && m_tdata[0])
    else $error("frame_good without frame_end, ready or store");

  // nothing stored means zero index and data and no frame end
  a_no_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0 && !m_tdata[19])
    else $error("store fields set without store_valid");

endmodule

bind serial_packet_frame_receiver spfr_checker u_spfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: bench/spfr_frame_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spfr_frame_checker
// Watches the byte stream, the result stream and the register port of the
// serial packet frame receiver. Each accepted input word runs through a
// cycle-free model of the framer, and the predicted result is queued. Each
// result word is compared field by field with the oldest queued one. The
// model's framing state is also exported so the stimulus can build frames
// whose checksum byte closes correctly.
// ---------------------------------------------------------------------------
module spfr_frame_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [spfr_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data
  input  logic [spfr_pkg::IN_TUSER_W-1:0]   s_tuser,  // [0] op, [1] overrun
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] store_valid, [8:1] store_index, [16:9] store_data, [17] packet_ready,
  // [18] frame_good, [19] frame_end, [20] direction, [28:21] tag_count,
  // [36:29] serial_number, [37] empty_packet, [39:38] zero
  input  logic [spfr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_we,
  input  logic [spfr_pkg::CfgAddrWidth-1:0] cfg_addr,
  input  logic [7:0]                        cfg_wdata,
  output int unsigned                       errors,
  output int unsigned                       waiting,
  output spfr_pkg::phase_t                  ph_now,
  output logic [7:0]                        sum_now,
  output logic [7:0]                        left_now,
  output logic                              rdy_now
);
  import spfr_pkg::*;

  localparam logic [7:0]  TagDivisor = 8'd3;
  localparam int unsigned ShowLimit  = 10;

  // Register copies
  logic [7:0] sync_cfg, min_cfg, max_cfg;

  // Framer model state
  phase_t     cur_phase;
  logic [7:0] run_sum;
  logic [7:0] bytes_left;
  logic [7:0] buf_idx;
  logic [7:0] tag_reg;
  logic [7:0] serial_hold;
  logic       empty_hold;
  logic       ready_hold;
  logic       dir_hold;

  result_t     frame_results_q[$];
  int unsigned fails   = 0;
  int unsigned pending = 0;

  assign errors   = fails;
  assign waiting  = pending;
  assign ph_now   = cur_phase;
  assign sum_now  = run_sum;
  assign left_now = bytes_left;
  assign rdy_now  = ready_hold;

  // Back to sync hunting with a fresh sum
  function automatic void drop_frame();
    buf_idx   = 8'd0;
    cur_phase = PH_HUNT;
    run_sum   = 8'd0;
  endfunction

  // One input word through the framer; returns the result word it yields
  function automatic result_t frame_next(input logic op, input logic [7:0] b,
                                         input logic ovr);
    result_t r;
    r = '0;
    if (op == OP_ACK) begin
      ready_hold = 1'b0;
    end else if (!ovr && !ready_hold) begin
      r.store_valid = 1'b1;
      r.store_index = buf_idx;
      r.store_data  = b;
      case (cur_phase)
        PH_HUNT: begin
          run_sum = run_sum + b;
          if (b == sync_cfg) begin
            buf_idx   = 8'd1;
            cur_phase = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          buf_idx = buf_idx + 8'd1;
          run_sum = run_sum + b;
          tag_reg = b;
          if (b > max_cfg || b < min_cfg) begin
            drop_frame();
          end else begin
            bytes_left = b - LEN_OVERHEAD;
            cur_phase  = PH_SERIAL;
          end
        end
        PH_SERIAL: begin
          buf_idx     = buf_idx + 8'd1;
          run_sum     = run_sum + b;
          serial_hold = b;
          bytes_left  = bytes_left - 8'd1;
          cur_phase   = PH_PAYLOAD;
          tag_reg     = tag_reg - TAG_HEADER;
          empty_hold  = 1'b0;
          if (tag_reg == TAG_EMPTY) empty_hold = 1'b1;
          else if (tag_reg == TAG_BAD) drop_frame();
          else tag_reg = tag_reg / TagDivisor;
          if (tag_reg > TAG_CAP) tag_reg = TAG_CAP;
        end
        default: begin
          bytes_left = bytes_left - 8'd1;
          buf_idx    = buf_idx + 8'd1;
          if (bytes_left == 8'd0) begin
            // checksum byte closes the frame
            r.frame_end = 1'b1;
            if (run_sum == b) begin
              r.frame_good = 1'b1;
              dir_hold     = ~dir_hold;
              ready_hold   = 1'b1;
            end
            drop_frame();
          end else begin
            run_sum = run_sum + b;
          end
        end
      endcase
    end
    r.packet_ready  = ready_hold;
    r.direction     = dir_hold;
    r.tag_count     = tag_reg;
    r.serial_number = serial_hold;
    r.empty_packet  = empty_hold;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return {$sformatf("st=%0b idx=%0d dat=%02h rdy=%0b good=%0b end=%0b ",
                      r.store_valid, r.store_index, r.store_data, r.packet_ready,
                      r.frame_good, r.frame_end),
            $sformatf("dir=%0b tags=%0d sn=%02h emp=%0b",
                      r.direction, r.tag_count, r.serial_number, r.empty_packet)};
  endfunction

  // Sample both channels and the register port at each rising edge
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      sync_cfg    = SYNC_RESET;
      min_cfg     = MIN_RESET;
      max_cfg     = MAX_RESET;
      cur_phase   = PH_HUNT;
      run_sum     = 8'd0;
      bytes_left  = 8'd0;
      buf_idx     = 8'd0;
      tag_reg     = 8'd0;
      serial_hold = 8'd0;
      empty_hold  = 1'b0;
      ready_hold  = 1'b0;
      dir_hold    = 1'b0;
      frame_results_q.delete();
    end else begin
      // result side
      if (m_tvalid && m_tready) begin
        got.store_valid   = m_tdata[0];
        got.store_index   = m_tdata[8:1];
        got.store_data    = m_tdata[16:9];
        got.packet_ready  = m_tdata[17];
        got.frame_good    = m_tdata[18];
        got.frame_end     = m_tdata[19];
        got.direction     = m_tdata[20];
        got.tag_count     = m_tdata[28:21];
        got.serial_number = m_tdata[36:29];
        got.empty_packet  = m_tdata[37];
        if (frame_results_q.size() == 0) begin
          fails++;
          if (fails <= ShowLimit) $display("unexpected result word %h", m_tdata);
        end else begin
          want = frame_results_q.pop_front();
          if (got !== want || m_tdata[39:38] !== 2'b00) begin
            fails++;
            if (fails <= ShowLimit) begin
              $display("result mismatch at %0t", $realtime);
              $display("  exp %s", show(want));
              $display("  act %s pad=%b", show(got), m_tdata[39:38]);
            end
          end
        end
      end
      // input side
      if (s_tvalid && s_tready) begin
        frame_results_q.push_back(frame_next(s_tuser[0], s_tdata[7:0], s_tuser[1]));
      end
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_SYNC_BYTE:  sync_cfg = cfg_wdata;
          REG_MIN_LENGTH: min_cfg  = cfg_wdata;
          REG_MAX_LENGTH: max_cfg  = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = frame_results_q.size();
  end

endmodule

// File: bench/tb_serial_packet_frame_receiver.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_serial_packet_frame_receiver
// Drives the frame receiver with a short directed run (acknowledges, dropped
// and ignored bytes, empty, bad and mismatched frames, rejected lengths) and
// then mostly well-formed frames with random content, stray bytes and noise,
// under several register settings including the extremes and an inverted
// length window. Both streams idle at random; one long result hold-off
// backs the block up. The checker instance does all comparison.
// ---------------------------------------------------------------------------
module tb_serial_packet_frame_receiver;
  import spfr_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned StallCycles = 80;
  localparam int unsigned IdlePct     = 32;
  localparam int unsigned TailCycles  = 8;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata;
  logic [IN_TUSER_W-1:0]   s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    cfg_we;
  logic [CfgAddrWidth-1:0] cfg_addr;
  logic [7:0]              cfg_wdata;

  int unsigned errors;
  int unsigned waiting;
  int unsigned cycles;
  int unsigned words_sent;
  phase_t      ph_now;
  logic [7:0]  sum_now;
  logic [7:0]  left_now;
  logic        rdy_now;
  bit          idle_on;
  bit          stall_req;

  // Register values as last written
  logic [7:0]  cur_sync, cur_min, cur_max;

  serial_packet_frame_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  spfr_frame_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .waiting   (waiting),
    .ph_now    (ph_now),
    .sum_now   (sum_now),
    .left_now  (left_now),
    .rdy_now   (rdy_now)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side: random idling plus one long hold-off on request
  initial begin : sink
    int unsigned held;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        m_tready <= 1'b0;
        for (held = 0; held < StallCycles; held++) @(negedge clk);
        stall_req = 1'b0;
      end
      m_tready <= !idle_on || ($urandom_range(99) >= IdlePct);
    end
  end

  // Offer one word and hold it until taken; starts and ends at a falling edge
  task automatic put_word(input logic op, input logic [7:0] b, input logic ovr);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {ovr, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_ACK || !ovr) words_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  task automatic load_config(input logic [7:0] sy, input logic [7:0] mn,
                             input logic [7:0] mx);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SYNC_BYTE;
    cfg_wdata <= sy;
    @(negedge clk);
    cfg_addr  <= REG_MIN_LENGTH;
    cfg_wdata <= mn;
    @(negedge clk);
    cfg_addr  <= REG_MAX_LENGTH;
    cfg_wdata <= mx;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_sync = sy;
    cur_min  = mn;
    cur_max  = mx;
  endtask

  // Length byte for the next frame: mostly short and in the window
  function automatic logic [7:0] pick_len();
    logic [7:0] lo;
    logic [7:0] hi;
    if (cur_min > cur_max) return 8'($urandom_range(255));
    if ($urandom_range(99) < 6) begin
      if (cur_min > 0) return 8'($urandom_range(cur_min - 1, 0));
      if (cur_max < 255) return 8'($urandom_range(255, cur_max + 1));
    end
    lo = (cur_min < 8'd4) ? 8'd4 : cur_min;
    if (cur_max < lo) return cur_max;
    hi = (cur_max - lo > 8'd16) ? lo + 8'd16 : cur_max;
    if ($urandom_range(99) < 4) hi = cur_max;
    return 8'($urandom_range(hi, lo));
  endfunction

  // Bring the framer back to hunting, then send strays and one frame whose
  // last byte closes the running sum (or breaks it when asked)
  task automatic send_frame(input logic [7:0] len, input int unsigned strays,
                            input bit corrupt, input bit noisy);
    logic [7:0] b;
    logic [7:0] flip;
    while (ph_now != PH_HUNT || rdy_now) begin
      if (rdy_now) put_word(OP_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else put_word(OP_BYTE, 8'($urandom_range(255)), 1'b0);
    end
    repeat (strays) begin
      do b = 8'($urandom_range(255)); while (b == cur_sync);
      put_word(OP_BYTE, b, 1'b0);
    end
    put_word(OP_BYTE, cur_sync, 1'b0);
    put_word(OP_BYTE, len, 1'b0);
    while (ph_now != PH_HUNT) begin
      if (noisy && $urandom_range(99) < 8) begin
        put_word(OP_BYTE, 8'($urandom_range(255)), 1'b1);
      end else if (noisy && $urandom_range(99) < 3) begin
        put_word(OP_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (ph_now == PH_PAYLOAD && left_now == 8'd1) begin
        flip = 8'($urandom_range(255, 1));
        b = corrupt ? (sum_now ^ flip) : sum_now;
        put_word(OP_BYTE, b, 1'b0);
      end else begin
        put_word(OP_BYTE, 8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  // Mostly frames, some raw noise, some acknowledges
  task automatic random_run(input int unsigned budget);
    int unsigned target;
    int unsigned pick;
    target = words_sent + budget;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame(pick_len(), $urandom_range(2), $urandom_range(9) == 0, 1'b1);
      end else if (pick < 88) begin
        repeat ($urandom_range(4, 1)) begin
          put_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
        end
      end else begin
        put_word(OP_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Stimulus
  initial begin : stimulus
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_SYNC_BYTE;
    cfg_wdata  = 8'h00;
    idle_on    = 1'b1;
    stall_req  = 1'b0;
    words_sent = 0;
    cur_sync   = SYNC_RESET;
    cur_min    = MIN_RESET;
    cur_max    = MAX_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: acknowledge with nothing pending, dropped overrun byte,
    // strays that enter the sum, then an empty frame that sets ready
    put_word(OP_ACK, 8'h00, 1'b0);
    put_word(OP_BYTE, 8'h3C, 1'b1);
    put_word(OP_BYTE, 8'h00, 1'b0);
    put_word(OP_BYTE, 8'hFF, 1'b0);
    send_frame(8'd5, 0, 1'b0, 1'b0);
    // bytes ignored while ready, then clear it
    put_word(OP_BYTE, 8'hAA, 1'b0);
    put_word(OP_BYTE, 8'h55, 1'b1);
    put_word(OP_ACK, 8'hFF, 1'b1);
    // bad tag count, checksum mismatch, lengths just outside the window
    send_frame(8'd6, 0, 1'b0, 1'b0);
    send_frame(8'd5, 0, 1'b1, 1'b0);
    send_frame(MAX_RESET + 8'd1, 0, 1'b0, 1'b0);
    send_frame(MIN_RESET - 8'd1, 0, 1'b0, 1'b0);

    // Reset settings: a stretch without idling, then idling and a hold-off
    idle_on = 1'b0;
    random_run(60);
    idle_on   = 1'b1;
    stall_req = 1'b1;
    random_run(60);

    // Widest window, zero sync; one short length so the index wraps
    settle();
    load_config(8'h00, 8'h00, 8'hFF);
    send_frame(8'($urandom_range(3)), 1, 1'b0, 1'b1);
    random_run(60);

    // Inverted window: every length is rejected
    settle();
    load_config(8'hFF, 8'hFF, 8'h00);
    random_run(40);

    // Random settings
    settle();
    load_config(8'($urandom_range(255)), 8'($urandom_range(8)),
                8'($urandom_range(255, 24)));
    random_run(80);

    settle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/spfr_pkg.sv
hw/rtl/spfr_in_stage.sv
hw/rtl/spfr_framer.sv
hw/rtl/spfr_out_stage.sv
hw/rtl/serial_packet_frame_receiver.sv
hw/rtl/spfr_checker.sv
bench/spfr_frame_checker.sv
bench/tb_serial_packet_frame_receiver.sv
